// ===== rtl/core/gzip_header_parser_assert.svh =====
// Assertion macros for the checker file.
`ifndef GZIP_HEADER_PARSER_ASSERT_SVH
`define GZIP_HEADER_PARSER_ASSERT_SVH

// Check a property that is disabled while reset is high.
`define GZHP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every edge, reset included.
`define GZHP_ASSERT_ALL(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/gzhp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package gzhp_pkg;

   typedef enum logic [2:0] {
      PH_FIXED   = 3'd0,
      PH_XLEN_LO = 3'd1,
      PH_XLEN_HI = 3'd2,
      PH_EXTRA   = 3'd3,
      PH_NAME    = 3'd4,
      PH_COMMENT = 3'd5,
      PH_HCRC    = 3'd6,
      PH_DONE    = 3'd7
   } phase_type;

   typedef enum logic [2:0] {
      ST_HEADER = 3'd0,
      ST_DONE   = 3'd1,
      ST_MAGIC  = 3'd2,
      ST_METHOD = 3'd3,
      ST_RESV   = 3'd4,
      ST_TRUNC  = 3'd5
   } status_type;

   localparam logic [7:0] MAGIC_ID1      = 8'd31;
   localparam logic [7:0] MAGIC_ID2      = 8'd139;
   localparam logic [7:0] METHOD_DEFLATE = 8'd8;
   localparam logic [7:0] FLAG_RESV_MASK = 8'he0;
   localparam int         FLAG_HCRC_BIT    = 1;
   localparam int         FLAG_EXTRA_BIT   = 2;
   localparam int         FLAG_NAME_BIT    = 3;
   localparam int         FLAG_COMMENT_BIT = 4;
   localparam logic [3:0] IDX_ID1        = 4'd0;
   localparam logic [3:0] IDX_ID2        = 4'd1;
   localparam logic [3:0] IDX_METHOD     = 4'd2;
   localparam logic [3:0] IDX_FLAGS      = 4'd3;
   localparam logic [3:0] IDX_FIXED_LAST = 4'd9;

   typedef struct packed {
      phase_type   phase;
      logic [3:0]  fixed_index;
      logic [7:0]  header_flags;
      logic [15:0] extra_remaining;
      logic [7:0]  extra_len_low;
      logic        crc_index;
      status_type  error_code;
   } parse_state_type;

   typedef struct packed {
      logic       payload_valid;
      logic [7:0] payload_byte;
      status_type parse_status;
   } result_type;

   localparam parse_state_type STATE_RESET = '{
      phase:           PH_FIXED,
      fixed_index:     4'd0,
      header_flags:    8'd0,
      extra_remaining: 16'd0,
      extra_len_low:   8'd0,
      crc_index:       1'b0,
      error_code:      ST_HEADER
   };

   // first optional section at or after 'from' that the flags ask for
   function automatic phase_type phase_from(input phase_type from, input logic [7:0] flags);
      phase_type ph;
      if (from <= PH_XLEN_LO && flags[FLAG_EXTRA_BIT]) begin
         ph = PH_XLEN_LO;
      end else if (from <= PH_NAME && flags[FLAG_NAME_BIT]) begin
         ph = PH_NAME;
      end else if (from <= PH_COMMENT && flags[FLAG_COMMENT_BIT]) begin
         ph = PH_COMMENT;
      end else if (from <= PH_HCRC && flags[FLAG_HCRC_BIT]) begin
         ph = PH_HCRC;
      end else begin
         ph = PH_DONE;
      end
      return ph;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/gzhp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface gzhp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       stream_start;
   logic       stream_last;

   modport source (output valid, in_byte, stream_start, stream_last, input ready);
   modport sink   (input valid, in_byte, stream_start, stream_last, output ready);
endinterface

interface gzhp_rsp_if;
   logic       valid;
   logic       ready;
   logic       payload_valid;
   logic [7:0] payload_byte;
   logic [2:0] parse_status;

   modport source (output valid, payload_valid, payload_byte, parse_status, input ready);
   modport sink   (input valid, payload_valid, payload_byte, parse_status, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/gzhp_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gzhp_step import gzhp_pkg::*; (
   input  parse_state_type state_cur,
   input  logic [7:0]      in_byte,
   input  logic            stream_start,
   input  logic            stream_last,
   output parse_state_type state_nxt,
   output result_type      result
);

   parse_state_type s;
   logic            byte_is_payload;

   always_comb begin
      s = stream_start ? STATE_RESET : state_cur;
      state_nxt = s;
      byte_is_payload = 1'b0;

      if (s.error_code == ST_HEADER) begin
         case (s.phase)
            PH_FIXED: begin
               if (s.fixed_index == IDX_ID1 && in_byte != MAGIC_ID1) begin
                  state_nxt.error_code = ST_MAGIC;
               end else if (s.fixed_index == IDX_ID2 && in_byte != MAGIC_ID2) begin
                  state_nxt.error_code = ST_MAGIC;
               end else if (s.fixed_index == IDX_METHOD && in_byte != METHOD_DEFLATE) begin
                  state_nxt.error_code = ST_METHOD;
               end else if (s.fixed_index == IDX_FLAGS) begin
                  if ((in_byte & FLAG_RESV_MASK) != 8'd0) begin
                     state_nxt.error_code = ST_RESV;
                  end
                  state_nxt.header_flags = in_byte;
               end
               if (state_nxt.error_code == ST_HEADER) begin
                  if (s.fixed_index >= IDX_FIXED_LAST) begin
                     state_nxt.fixed_index = 4'd0;
                     state_nxt.phase = phase_from(PH_XLEN_LO, s.header_flags);
                  end else begin
                     state_nxt.fixed_index = s.fixed_index + 4'd1;
                  end
               end
            end
            PH_XLEN_LO: begin
               state_nxt.extra_len_low = in_byte;
               state_nxt.phase = PH_XLEN_HI;
            end
            PH_XLEN_HI: begin
               state_nxt.extra_remaining = {in_byte, s.extra_len_low};
               if ({in_byte, s.extra_len_low} == 16'd0) begin
                  state_nxt.phase = phase_from(PH_NAME, s.header_flags);
               end else begin
                  state_nxt.phase = PH_EXTRA;
               end
            end
            PH_EXTRA: begin
               state_nxt.extra_remaining = s.extra_remaining - 16'd1;
               if (s.extra_remaining == 16'd1) begin
                  state_nxt.phase = phase_from(PH_NAME, s.header_flags);
               end
            end
            PH_NAME: begin
               if (in_byte == 8'd0) begin
                  state_nxt.phase = phase_from(PH_COMMENT, s.header_flags);
               end
            end
            PH_COMMENT: begin
               if (in_byte == 8'd0) begin
                  state_nxt.phase = phase_from(PH_HCRC, s.header_flags);
               end
            end
            PH_HCRC: begin
               if (s.crc_index) begin
                  state_nxt.crc_index = 1'b0;
                  state_nxt.phase = PH_DONE;
               end else begin
                  state_nxt.crc_index = 1'b1;
               end
            end
            default: begin
               byte_is_payload = 1'b1;
            end
         endcase
         if (state_nxt.error_code == ST_HEADER && stream_last && state_nxt.phase != PH_DONE) begin
            state_nxt.error_code = ST_TRUNC;
         end
      end
   end

   always_comb begin
      if (state_nxt.error_code != ST_HEADER) begin
         result.payload_valid = 1'b0;
         result.payload_byte  = 8'd0;
         result.parse_status  = state_nxt.error_code;
      end else begin
         result.payload_valid = byte_is_payload;
         result.payload_byte  = byte_is_payload ? in_byte : 8'd0;
         result.parse_status  = (state_nxt.phase == PH_DONE) ? ST_DONE : ST_HEADER;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/gzip_header_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A result beat appears in the cycle after its request beat is accepted.
// Throughput: one byte per cycle while each result beat is taken; the parse state updates in the accepting cycle.
// The result register frees in the same cycle it is taken, so a stall only blocks
// new requests while the held result is not taken.
// Reset (synchronous): parser returns to the fixed header phase, result register empty.
module gzip_header_parser import gzhp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   gzhp_req_if.sink          req_if,
   gzhp_rsp_if.source        rsp_if
);

   parse_state_type state_ff;
   parse_state_type state_in;
   result_type      result_ff;
   result_type      result_in;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   logic            req_fire;

   gzhp_step u_step (
      .state_cur    (state_ff),
      .in_byte      (req_if.in_byte),
      .stream_start (req_if.stream_start),
      .stream_last  (req_if.stream_last),
      .state_nxt    (state_in),
      .result       (result_in)
   );

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_fire     = req_if.valid && req_if.ready;
   assign rsp_valid_in = req_fire || (rsp_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         result_ff <= result_in;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.payload_valid = result_ff.payload_valid;
   assign rsp_if.payload_byte  = result_ff.payload_byte;
   assign rsp_if.parse_status  = result_ff.parse_status;

endmodule
`default_nettype wire

// ===== rtl/core/gzhp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "gzip_header_parser_assert.svh"
module gzhp_checker import gzhp_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       payload_valid,
   input logic [7:0] payload_byte,
   input logic [2:0] parse_status
);

   `GZHP_ASSERT_ALL(a_reset_empty, clock, $past(reset) |-> !rsp_valid, "result beat right after reset")
   `GZHP_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "result beat dropped while stalled")
   `GZHP_ASSERT(a_payload_done, clock, reset, rsp_valid && payload_valid |-> parse_status == ST_DONE, "payload beat outside done status")
   `GZHP_ASSERT(a_byte_zero, clock, reset, rsp_valid && !payload_valid |-> payload_byte == 8'd0, "non-payload beat carries a byte")
   `GZHP_ASSERT(a_status_range, clock, reset, rsp_valid |-> parse_status <= ST_TRUNC, "status code out of range")

endmodule

bind gzip_header_parser gzhp_checker u_gzhp_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .payload_valid (rsp_if.payload_valid),
   .payload_byte  (rsp_if.payload_byte),
   .parse_status  (rsp_if.parse_status)
);
`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top import gzhp_pkg::*; ();

   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 150;
   localparam int DRAIN_CYCLES = 8;

   class gzip_header_tracker;
      phase_type   phase;
      logic [3:0]  fixed_idx;
      logic [7:0]  flags;
      logic [15:0] extra_left;
      logic [7:0]  xlen_low;
      logic        crc_idx;
      status_type  err;
      result_type  expected_results[$];
      int          failures;

      function new();
         failures = 0;
         clear();
      endfunction

      function void clear();
         phase = PH_FIXED;
         fixed_idx = 4'd0;
         flags = 8'd0;
         extra_left = 16'd0;
         xlen_low = 8'd0;
         crc_idx = 1'b0;
         err = ST_HEADER;
      endfunction

      function bit section_wanted(phase_type p);
         case (p)
            PH_XLEN_LO: return flags[FLAG_EXTRA_BIT];
            PH_NAME:    return flags[FLAG_NAME_BIT];
            PH_COMMENT: return flags[FLAG_COMMENT_BIT];
            PH_HCRC:    return flags[FLAG_HCRC_BIT];
            default:    return 1'b0;
         endcase
      endfunction

      function phase_type next_section(phase_type from);
         for (int p = int'(from); p < int'(PH_DONE); p++) begin
            if (section_wanted(phase_type'(p))) return phase_type'(p);
         end
         return PH_DONE;
      endfunction

      function void note_byte(logic [7:0] b, logic start, logic last);
         result_type r;
         logic       pass;
         pass = 1'b0;
         if (start) clear();
         if (err == ST_HEADER) begin
            case (phase)
               PH_FIXED: begin
                  if (fixed_idx == IDX_ID1 && b != MAGIC_ID1) err = ST_MAGIC;
                  else if (fixed_idx == IDX_ID2 && b != MAGIC_ID2) err = ST_MAGIC;
                  else if (fixed_idx == IDX_METHOD && b != METHOD_DEFLATE) err = ST_METHOD;
                  else if (fixed_idx == IDX_FLAGS) begin
                     if ((b & FLAG_RESV_MASK) != 8'd0) err = ST_RESV;
                     flags = b;
                  end
                  if (err == ST_HEADER) begin
                     if (fixed_idx >= IDX_FIXED_LAST) begin
                        fixed_idx = 4'd0;
                        phase = next_section(PH_XLEN_LO);
                     end else begin
                        fixed_idx = fixed_idx + 4'd1;
                     end
                  end
               end
               PH_XLEN_LO: begin
                  xlen_low = b;
                  phase = PH_XLEN_HI;
               end
               PH_XLEN_HI: begin
                  extra_left = {b, xlen_low};
                  phase = (extra_left == 16'd0) ? next_section(PH_NAME) : PH_EXTRA;
               end
               PH_EXTRA: begin
                  extra_left = extra_left - 16'd1;
                  if (extra_left == 16'd0) phase = next_section(PH_NAME);
               end
               PH_NAME: begin
                  if (b == 8'd0) phase = next_section(PH_COMMENT);
               end
               PH_COMMENT: begin
                  if (b == 8'd0) phase = next_section(PH_HCRC);
               end
               PH_HCRC: begin
                  if (crc_idx) begin
                     crc_idx = 1'b0;
                     phase = PH_DONE;
                  end else begin
                     crc_idx = 1'b1;
                  end
               end
               default: pass = 1'b1;
            endcase
            if (err == ST_HEADER && last && phase != PH_DONE) err = ST_TRUNC;
         end
         if (err != ST_HEADER) begin
            r.payload_valid = 1'b0;
            r.payload_byte = 8'd0;
            r.parse_status = err;
         end else begin
            r.payload_valid = pass;
            r.payload_byte = pass ? b : 8'd0;
            r.parse_status = (phase == PH_DONE) ? ST_DONE : ST_HEADER;
         end
         expected_results.push_back(r);
      endfunction

      function void check_result(logic pv, logic [7:0] pb, logic [2:0] ps);
         result_type e;
         if (expected_results.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("tb_top: result beat with nothing expected: valid=%0b byte=%02h status=%0d",
                        pv, pb, ps);
            return;
         end
         e = expected_results.pop_front();
         if (pv !== e.payload_valid || pb !== e.payload_byte || ps !== e.parse_status) begin
            failures++;
            if (failures <= 10)
               $display("tb_top: mismatch exp valid=%0b byte=%02h status=%0d, got valid=%0b byte=%02h status=%0d",
                        e.payload_valid, e.payload_byte, e.parse_status, pv, pb, ps);
         end
      endfunction

      function int outstanding();
         return expected_results.size();
      endfunction
   endclass

   typedef struct {
      logic [7:0] data;
      logic       start;
      logic       last;
   } file_beat_t;

   logic clock = 1'b0;
   logic reset;

   gzhp_req_if req_if();
   gzhp_rsp_if rsp_if();

   gzip_header_parser dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_if),
      .rsp_if(rsp_if)
   );

   gzip_header_tracker tracker = new();
   file_beat_t         beats[$];
   int                 idle_pct = 0;
   int                 stall_pct = 0;
   int                 sent_count = 0;
   int                 hold_requests = 0;
   int                 hold_served = 0;
   int                 hold_left = 0;
   int                 quiet_cycles = 0;

   always #5 clock = ~clock;

   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready)
            tracker.check_result(rsp_if.payload_valid, rsp_if.payload_byte, rsp_if.parse_status);
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic start, input logic last);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.in_byte <= b;
      req_if.stream_start <= start;
      req_if.stream_last <= last;
      do @(posedge clock); while (!req_if.ready);
      tracker.note_byte(b, start, last);
      sent_count++;
   endtask

   task automatic make_stream();
      logic [7:0] raw[$];
      logic [7:0] flags;
      file_beat_t fb;
      int         hdr_len;
      int         n;
      int         pick;
      int         idx;
      // noise: short random runs
      if ($urandom_range(0, 99) < 10) begin
         n = $urandom_range(1, 8);
         for (int i = 0; i < n; i++) begin
            fb.data = 8'($urandom_range(0, 255));
            fb.start = (i == 0);
            fb.last = 1'($urandom_range(0, 1));
            beats.push_back(fb);
         end
         return;
      end
      flags = 8'($urandom_range(0, 31));
      if ($urandom_range(0, 11) == 0) flags = flags | (8'h20 << $urandom_range(0, 2));
      raw.push_back(MAGIC_ID1);
      raw.push_back(MAGIC_ID2);
      raw.push_back(METHOD_DEFLATE);
      raw.push_back(flags);
      for (int i = 0; i < 6; i++) raw.push_back(8'($urandom_range(0, 255)));
      if (flags[FLAG_EXTRA_BIT]) begin
         pick = $urandom_range(0, 9);
         if (pick < 2) n = 0;
         else if (pick < 9) n = $urandom_range(1, 8);
         else n = $urandom_range(9, 300);
         raw.push_back(n[7:0]);
         raw.push_back(n[15:8]);
         for (int i = 0; i < n; i++) raw.push_back(8'($urandom_range(0, 255)));
      end
      if (flags[FLAG_NAME_BIT]) begin
         n = $urandom_range(0, 6);
         for (int i = 0; i < n; i++) raw.push_back(8'($urandom_range(1, 255)));
         raw.push_back(8'd0);
      end
      if (flags[FLAG_COMMENT_BIT]) begin
         n = $urandom_range(0, 6);
         for (int i = 0; i < n; i++) raw.push_back(8'($urandom_range(1, 255)));
         raw.push_back(8'd0);
      end
      if (flags[FLAG_HCRC_BIT]) begin
         raw.push_back(8'($urandom_range(0, 255)));
         raw.push_back(8'($urandom_range(0, 255)));
      end
      hdr_len = raw.size();
      n = $urandom_range(0, 10);
      for (int i = 0; i < n; i++) raw.push_back(8'($urandom_range(0, 255)));
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         idx = $urandom_range(0, 2);
         raw[idx] = raw[idx] ^ 8'($urandom_range(1, 255));
      end else if (pick < 22) begin
         n = $urandom_range(1, hdr_len - 1);
         raw = raw[0:n-1];
      end
      for (int i = 0; i < raw.size(); i++) begin
         fb.data = raw[i];
         fb.start = (i == 0);
         fb.last = (i == raw.size() - 1);
         beats.push_back(fb);
      end
      // drop the end marker now and then so the next start cuts in
      if ($urandom_range(0, 9) == 0) beats[beats.size() - 1].last = 1'b0;
      // bytes past the end of the file without a new start
      if ($urandom_range(0, 9) == 0) begin
         n = $urandom_range(1, 3);
         for (int i = 0; i < n; i++) begin
            fb.data = 8'($urandom_range(0, 255));
            fb.start = 1'b0;
            fb.last = 1'($urandom_range(0, 1));
            beats.push_back(fb);
         end
      end
   endtask

   task automatic run_phase(input int idle, input int stall, input int items, input bit squeeze);
      int         base;
      file_beat_t fb;
      base = sent_count;
      idle_pct = idle;
      stall_pct = stall;
      if (squeeze) hold_requests++;
      while (sent_count - base < items) begin
         make_stream();
         while (beats.size() > 0) begin
            fb = beats.pop_front();
            send_byte(fb.data, fb.start, fb.last);
         end
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.in_byte <= 8'd0;
      req_if.stream_start <= 1'b0;
      req_if.stream_last <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // bad magic on a one-byte file, bad second magic, bad method, reserved flags and a cut header
      send_byte(8'h00, 1'b1, 1'b1);
      send_byte(MAGIC_ID1, 1'b1, 1'b0);
      send_byte(8'h8a, 1'b0, 1'b0);
      send_byte(8'hff, 1'b0, 1'b1);
      send_byte(MAGIC_ID1, 1'b1, 1'b0);
      send_byte(MAGIC_ID2, 1'b0, 1'b0);
      send_byte(8'h07, 1'b0, 1'b0);
      send_byte(MAGIC_ID1, 1'b1, 1'b0);
      send_byte(MAGIC_ID2, 1'b0, 1'b0);
      send_byte(METHOD_DEFLATE, 1'b0, 1'b0);
      send_byte(8'h80, 1'b0, 1'b0);
      send_byte(MAGIC_ID1, 1'b1, 1'b0);
      send_byte(MAGIC_ID2, 1'b0, 1'b1);
      // minimal header with the text hint, payload, then a byte past the end
      send_byte(MAGIC_ID1, 1'b1, 1'b0);
      send_byte(MAGIC_ID2, 1'b0, 1'b0);
      send_byte(METHOD_DEFLATE, 1'b0, 1'b0);
      send_byte(8'h01, 1'b0, 1'b0);
      for (int i = 0; i < 6; i++) send_byte((i % 2) ? 8'h00 : 8'hff, 1'b0, 1'b0);
      send_byte(8'hff, 1'b0, 1'b0);
      send_byte(8'h00, 1'b0, 1'b1);
      send_byte(8'h5a, 1'b0, 1'b0);

      run_phase(0, 0, 256, 1'b1);
      run_phase(62, 0, 256, 1'b0);
      run_phase(0, 62, 256, 1'b0);
      run_phase(33, 33, 256, 1'b0);
      req_if.valid <= 1'b0;

      while (tracker.outstanding() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.failures == 0 && tracker.outstanding() == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
